FILE: rtl/local_lee_wiener_filter_assert.svh
// ----------------------------------------------------------------------------
// local lee wiener filter assertion macros
// shared property shapes, clocked on i_clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef LOCAL_LEE_WIENER_FILTER_ASSERT_SVH
`define LOCAL_LEE_WIENER_FILTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LLWF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LLWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/llwf_pkg.sv
// ----------------------------------------------------------------------------
// llwf_pkg
// sizes, codes and shared types of the local lee wiener filter
// ----------------------------------------------------------------------------
package llwf_pkg;

    // frame store geometry
    localparam int MAX_CHANNELS    = 16;
    localparam int MAX_TICKS       = 1024;
    localparam int MAX_HALF_WINDOW = 7;

    // fixed field widths
    localparam int CMD_W      = 1;
    localparam int CH_W       = 4;
    localparam int TK_W       = 10;
    localparam int SMP_W      = 16;
    localparam int OUT_W      = 24;
    localparam int NC_W       = 5;
    localparam int NT_W       = 11;
    localparam int HW_W       = 3;
    localparam int NOISE_W    = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam int RAM_DEPTH = MAX_CHANNELS * (1 << TK_W);

    // window statistics
    localparam int WIN_MAX   = (2 * MAX_HALF_WINDOW + 1) * (2 * MAX_HALF_WINDOW + 1);
    localparam int N_W       = $clog2(WIN_MAX + 1);
    localparam int NN_W      = 2 * N_W;
    localparam int SUM_W     = SMP_W + N_W;
    localparam int SMAG_W    = SUM_W;
    localparam int SQ1_W     = 2 * SMP_W;
    localparam int SQ_W      = 2 * SMP_W - 1 + N_W;
    localparam int NQ_W      = N_W + SQ_W;
    localparam int FRAC_W    = 8;
    localparam int GAIN_FRAC = 16;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam int MEAN_W    = SMP_W + FRAC_W + 1;
    localparam int DIFF_W    = MEAN_W + 1;
    localparam int PROD_W    = DIFF_W + GAIN_W + 1;
    localparam int CORR_W    = PROD_W - GAIN_FRAC;
    localparam int RES_W     = CORR_W + 2;
    localparam int MEAN_BITS = SMAG_W + FRAC_W;

    // shared divider
    localparam int DVD_W     = NOISE_W + GAIN_FRAC;
    localparam int DVS_W     = NOISE_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FILTER = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIN_CH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIN_TK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_VAR    = 3'd4;

    // register reset values
    localparam logic [NC_W-1:0]    NC_RST    = 5'd16;
    localparam logic [NT_W-1:0]    NT_RST    = 11'd1024;
    localparam logic [HW_W-1:0]    HW_RST    = 3'd1;
    localparam logic [NOISE_W-1:0] NOISE_RST = '0;

    typedef struct packed {
        logic                 start;
        logic [DVD_W-1:0]     dividend;
        logic [DVS_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/llwf_ram.sv
// ----------------------------------------------------------------------------
// llwf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module llwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/llwf_div.sv
// ----------------------------------------------------------------------------
// llwf_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module llwf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  llwf_pkg::t_div_req i_req,
    output llwf_pkg::t_div_rsp o_rsp
);
    import llwf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W:0]       shifted;
    logic [DVS_W+1:0]     trial;
    logic                 fits;

    // dividend is left aligned by the caller, quotient collects in the low bits
    assign shifted = {r_rem, r_quo[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dvs};
    assign fits    = !trial[DVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: rtl/local_lee_wiener_filter.sv
// ----------------------------------------------------------------------------
// local_lee_wiener_filter
// lee adaptive wiener filter over a stored frame of 16-bit samples
// ----------------------------------------------------------------------------
// Requests arrive on the i_in_valid / o_in_ready channel; each one gives
// exactly one result on o_out_valid / i_out_ready. A write request stores a
// sample when its index is in range and is acknowledged with filtered_value
// zero. A filter request with its index in range scans the clipped window
// through the frame ram, one sample per cycle, then runs the mean and
// variance divisions of 32 and 56 steps on one shared bit-serial divider,
// and a gain division of 56 steps unless the variance is zero or below the
// noise variance. One request is worked on at a time and o_in_ready is high
// only while the block is idle. A result waits in the output register while
// the receiver stalls; a new request is still taken then and its result
// waits until the register frees. Reset clears the control state and loads
// the register defaults; the frame ram is not cleared, and every pixel of a
// window must be written before it is filtered. Registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data, and the user must write them
// only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "local_lee_wiener_filter_assert.svh"

module local_lee_wiener_filter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [llwf_pkg::CMD_W-1:0]            i_command,
    input  logic [llwf_pkg::CH_W-1:0]             i_channel,
    input  logic [llwf_pkg::TK_W-1:0]             i_tick,
    input  logic signed [llwf_pkg::SMP_W-1:0]     i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [llwf_pkg::OUT_W-1:0]     o_filtered_value,
    output logic                                  o_is_filter_result,
    output logic                                  o_index_error,
    input  logic                                  i_cfg_we,
    input  logic [llwf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [llwf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import llwf_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_FLUSH   = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_MEAN_GO = 4'd4;
    localparam logic [3:0] S_MEAN_WT = 4'd5;
    localparam logic [3:0] S_VAR_GO  = 4'd6;
    localparam logic [3:0] S_VAR_WT  = 4'd7;
    localparam logic [3:0] S_GAIN_GO = 4'd8;
    localparam logic [3:0] S_GAIN_WT = 4'd9;
    localparam logic [3:0] S_PROD    = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    // configuration registers
    logic [NC_W-1:0]    r_num_channels;
    logic [NT_W-1:0]    r_num_ticks;
    logic [HW_W-1:0]    r_half_ch;
    logic [HW_W-1:0]    r_half_tk;
    logic [NOISE_W-1:0] r_noise;

    // sequencer
    logic [3:0] r_state;
    logic [3:0] n_state;

    // request and window
    logic [CH_W-1:0] r_ch;
    logic [TK_W-1:0] r_tk;
    logic            r_is_filt;
    logic            r_err;
    logic [CH_W-1:0] r_a;
    logic [TK_W-1:0] r_b;
    logic [CH_W-1:0] r_c1;
    logic [TK_W-1:0] r_t0;
    logic [TK_W-1:0] r_t1;

    // accumulation pipeline
    logic                    r_p1_v;
    logic                    r_p1_ctr;
    logic                    r_p2_v;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ1_W-1:0]        r_sq;
    logic [SQ_W-1:0]         r_q;
    logic [N_W-1:0]          r_n;
    logic signed [SMP_W-1:0] r_center;

    // statistics
    logic [SMAG_W-1:0]        r_smag;
    logic                     r_sneg;
    logic [NQ_W-1:0]          r_nq;
    logic [NQ_W-1:0]          r_ss;
    logic [NN_W-1:0]          r_nn;
    logic signed [MEAN_W-1:0] r_mean;
    logic [NOISE_W-1:0]       r_var;
    logic [GAIN_W-1:0]        r_gain;
    logic signed [PROD_W-1:0] r_prod;
    logic [OUT_W-1:0]         r_res;

    // output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_value;
    logic                    r_out_filt;
    logic                    r_out_err;

    // combinational
    logic                     accept;
    logic                     out_free;
    logic [NC_W-1:0]          nc;
    logic [NT_W-1:0]          nt;
    logic [NC_W-1:0]          nc_m1;
    logic [NT_W-1:0]          nt_m1;
    logic [HW_W-1:0]          hc;
    logic [HW_W-1:0]          ht;
    logic                     in_err;
    logic [CH_W-1:0]          c0;
    logic [CH_W-1:0]          c1;
    logic [TK_W-1:0]          t0;
    logic [TK_W-1:0]          t1;
    logic [NC_W-1:0]          c_hi;
    logic [NT_W-1:0]          t_hi;
    logic                     scan_last;
    logic                     ram_we;
    logic [SMP_W-1:0]         ram_rdata;
    logic signed [SMP_W-1:0]  rd_x;
    logic signed [SQ1_W-1:0]  sq_full;
    logic [SMAG_W-1:0]        sum_mag;
    logic [NQ_W-1:0]          var_num;
    logic [NOISE_W-1:0]       var_q;
    logic                     skip_gain;
    logic signed [MEAN_W-1:0] mean_pos;
    logic signed [DIFF_W-1:0] diff;
    logic signed [GAIN_W:0]   gain_s;
    logic [PROD_W-1:0]        pmag;
    logic [CORR_W-1:0]        corr_mag;
    logic signed [RES_W-1:0]  corr;
    logic signed [RES_W-1:0]  res_full;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // frame size and window bounds, clipped to the frame
    always_comb begin
        nc    = (r_num_channels > NC_W'(MAX_CHANNELS)) ? NC_W'(MAX_CHANNELS) : r_num_channels;
        nt    = (r_num_ticks > NT_W'(MAX_TICKS)) ? NT_W'(MAX_TICKS) : r_num_ticks;
        hc    = (r_half_ch > HW_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : r_half_ch;
        ht    = (r_half_tk > HW_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : r_half_tk;
        nc_m1 = nc - NC_W'(1);
        nt_m1 = nt - NT_W'(1);
        in_err = (NC_W'(i_channel) >= nc) || (NT_W'(i_tick) >= nt);
        c0    = (i_channel > CH_W'(hc)) ? i_channel - CH_W'(hc) : '0;
        t0    = (i_tick > TK_W'(ht)) ? i_tick - TK_W'(ht) : '0;
        c_hi  = NC_W'(i_channel) + NC_W'(hc);
        t_hi  = NT_W'(i_tick) + NT_W'(ht);
        c1    = (c_hi < nc) ? c_hi[CH_W-1:0] : nc_m1[CH_W-1:0];
        t1    = (t_hi < nt) ? t_hi[TK_W-1:0] : nt_m1[TK_W-1:0];
    end

    assign scan_last = (r_a == r_c1) && (r_b == r_t1);
    assign ram_we    = accept && (i_command == CMD_WRITE) && !in_err;
    assign rd_x      = $signed(ram_rdata);
    assign sq_full   = SQ1_W'(rd_x) * SQ1_W'(rd_x);
    assign sum_mag   = r_sum[SUM_W-1] ? SMAG_W'(-r_sum) : SMAG_W'(r_sum);
    assign var_num   = r_nq - r_ss;
    assign var_q     = div_rsp.quotient[NOISE_W-1:0];
    assign skip_gain = (r_noise > var_q) || (var_q == '0);
    assign mean_pos  = $signed({1'b0, div_rsp.quotient[MEAN_W-2:0]});

    // correction term, truncated toward zero
    always_comb begin
        diff     = DIFF_W'($signed({r_center, {FRAC_W{1'b0}}})) - DIFF_W'(r_mean);
        gain_s   = $signed({1'b0, r_gain});
        pmag     = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        corr_mag = pmag[PROD_W-1:GAIN_FRAC];
        corr     = r_prod[PROD_W-1] ? -$signed({2'b00, corr_mag}) : $signed({2'b00, corr_mag});
        res_full = RES_W'(r_mean) + corr;
    end

    // divider requests
    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_MEAN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_smag, {FRAC_W{1'b0}}, {(DVD_W - MEAN_BITS){1'b0}}};
                div_req.divisor  = DVS_W'(r_n);
                div_req.steps    = DIV_CNT_W'(MEAN_BITS);
            end
            S_VAR_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'({var_num, {FRAC_W{1'b0}}});
                div_req.divisor  = DVS_W'(r_nn);
                div_req.steps    = DIV_CNT_W'(DVD_W);
            end
            S_GAIN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_var - r_noise, {GAIN_FRAC{1'b0}}};
                div_req.divisor  = r_var;
                div_req.steps    = DIV_CNT_W'(DVD_W);
            end
            default: begin
            end
        endcase
    end

    llwf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    llwf_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RAM_DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({i_channel, i_tick}),
        .i_wdata (i_sample),
        .i_raddr ({r_a, r_b}),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_command == CMD_FILTER && !in_err) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:     n_state = S_MEAN_GO;
            S_MEAN_GO: n_state = S_MEAN_WT;
            S_MEAN_WT: begin
                if (div_rsp.done) begin
                    n_state = S_VAR_GO;
                end
            end
            S_VAR_GO:  n_state = S_VAR_WT;
            S_VAR_WT: begin
                if (div_rsp.done) begin
                    n_state = skip_gain ? S_DONE : S_GAIN_GO;
                end
            end
            S_GAIN_GO: n_state = S_GAIN_WT;
            S_GAIN_WT: begin
                if (div_rsp.done) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:    n_state = S_FIN;
            S_FIN:     n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_p1_v         <= 1'b0;
            r_p1_ctr       <= 1'b0;
            r_p2_v         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_num_channels <= NC_RST;
            r_num_ticks    <= NT_RST;
            r_half_ch      <= HW_RST;
            r_half_tk      <= HW_RST;
            r_noise        <= NOISE_RST;
        end else begin
            r_state  <= n_state;
            r_p1_v   <= (r_state == S_SCAN);
            r_p1_ctr <= (r_state == S_SCAN) && (r_a == r_ch) && (r_b == r_tk);
            r_p2_v   <= r_p1_v;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NUM_CHANNELS: r_num_channels <= i_cfg_data[NC_W-1:0];
                    REG_NUM_TICKS:    r_num_ticks    <= i_cfg_data[NT_W-1:0];
                    REG_HALF_WIN_CH:  r_half_ch      <= i_cfg_data[HW_W-1:0];
                    REG_HALF_WIN_TK:  r_half_tk      <= i_cfg_data[HW_W-1:0];
                    REG_NOISE_VAR:    r_noise        <= i_cfg_data[NOISE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_ch      <= i_channel;
                    r_tk      <= i_tick;
                    r_is_filt <= (i_command == CMD_FILTER);
                    r_err     <= in_err;
                    r_res     <= '0;
                    r_a       <= c0;
                    r_b       <= t0;
                    r_c1      <= c1;
                    r_t0      <= t0;
                    r_t1      <= t1;
                    r_sum     <= '0;
                    r_q       <= '0;
                    r_n       <= '0;
                end
            end
            S_SCAN: begin
                if (r_b == r_t1) begin
                    r_b <= r_t0;
                    r_a <= r_a + CH_W'(1);
                end else begin
                    r_b <= r_b + TK_W'(1);
                end
            end
            S_MUL: begin
                r_smag <= sum_mag;
                r_sneg <= r_sum[SUM_W-1];
                r_nq   <= NQ_W'(r_n) * NQ_W'(r_q);
                r_ss   <= NQ_W'(sum_mag) * NQ_W'(sum_mag);
                r_nn   <= NN_W'(r_n) * NN_W'(r_n);
            end
            S_MEAN_WT: begin
                if (div_rsp.done) begin
                    r_mean <= r_sneg ? -mean_pos : mean_pos;
                end
            end
            S_VAR_WT: begin
                if (div_rsp.done) begin
                    r_var <= var_q;
                    if (skip_gain) begin
                        r_res <= r_mean[OUT_W-1:0];
                    end
                end
            end
            S_GAIN_WT: begin
                if (div_rsp.done) begin
                    r_gain <= div_rsp.quotient[GAIN_W-1:0];
                end
            end
            S_PROD: begin
                r_prod <= PROD_W'(diff) * PROD_W'(gain_s);
            end
            S_FIN: begin
                r_res <= res_full[OUT_W-1:0];
            end
            default: begin
            end
        endcase

        // sample stage: sum and square, then sum of squares
        if (r_p1_v) begin
            r_sum <= r_sum + SUM_W'(rd_x);
            r_sq  <= sq_full;
            r_n   <= r_n + N_W'(1);
            if (r_p1_ctr) begin
                r_center <= rd_x;
            end
        end
        if (r_p2_v) begin
            r_q <= r_q + SQ_W'(r_sq);
        end

        if (r_state == S_DONE && out_free) begin
            r_out_value <= $signed(r_res);
            r_out_filt  <= r_is_filt;
            r_out_err   <= r_err;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_filtered_value   = r_out_value;
    assign o_is_filter_result = r_out_filt;
    assign o_index_error      = r_out_err;

    `LLWF_ASSERT_SAME(a_div_idle_start, div_req.start, !div_rsp.busy, "divider started while busy")
    `LLWF_ASSERT_SAME(a_ack_zero, o_out_valid && (!o_is_filter_result || o_index_error), o_filtered_value == '0, "write ack or index error with nonzero value")
    `LLWF_ASSERT_SAME(a_win_count, r_state == S_MUL, (r_n != '0) && (r_n <= N_W'(WIN_MAX)), "window sample count out of range")
    `LLWF_ASSERT_NEXT(a_done_loads, r_state == S_DONE && out_free, o_out_valid && (r_state == S_IDLE), "result not loaded into output register")

endmodule
